>>> rtl/d2wpmd_pkg.sv
// Shared types and constants of the window-pair distance search block.
`timescale 1ns / 1ps
`default_nettype none
package d2wpmd_pkg;

   localparam int POS_W   = 10;
   localparam int WORD_W  = 12;
   localparam int CNT_W   = 11;
   localparam int SCORE_W = 22;
   localparam int THR_W   = 16;
   localparam int WLEN_W  = 11;
   localparam int KLEN_W  = 3;
   localparam int CLR_W   = 16;
   localparam int CSR_W   = 2;

   localparam logic [CSR_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_W-1:0] CSR_WORD_LENGTH   = 2'd1;
   localparam logic [CSR_W-1:0] CSR_THRESHOLD     = 2'd2;

   localparam logic [1:0] ACT_LOAD_SRC = 2'd0;
   localparam logic [1:0] ACT_LOAD_TGT = 2'd1;
   localparam logic [1:0] ACT_COMPUTE  = 2'd2;

   localparam logic [1:0] STAT_FULL  = 2'd0;
   localparam logic [1:0] STAT_THR   = 2'd1;
   localparam logic [1:0] STAT_SHORT = 2'd2;

   typedef struct packed {
      logic              load_en;
      logic              load_src;
      logic [POS_W-1:0]  load_pos;
      logic [WORD_W-1:0] load_word;
      logic              clear_en;
      logic [CLR_W-1:0]  clear_addr;
      logic              word_rd;
      logic              op_src;
      logic [POS_W-1:0]  op_pos;
      logic              mod_en;
      logic              cnt_rd;
      logic              upd_en;
      logic              op_put;
      logic              note_en;
      logic              note_init;
      logic              rsp_load;
      logic              rsp_short;
      logic [THR_W-1:0]  threshold;
   } cmd_type;

   typedef struct packed {
      logic best_le_thr;
   } stat_type;

endpackage
`default_nettype wire

>>> rtl/d2wpmd_datapath.sv
// Datapath: word stores, count tables, score update and result score register.
`timescale 1ns / 1ps
`default_nettype none
module d2wpmd_datapath #(
   parameter int WORD_SPACE = 4096,
   parameter int MAX_WORDS  = 1024
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  d2wpmd_pkg::cmd_type           cmd,
   output d2wpmd_pkg::stat_type                stat,
   output logic [d2wpmd_pkg::SCORE_W-1:0]      score
);

   localparam int AW      = $clog2(MAX_WORDS);
   localparam int CW      = $clog2(WORD_SPACE);
   localparam int RECIP   = ((2 ** 24) + WORD_SPACE - 1) / WORD_SPACE;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PX_W    = 17;
   localparam int WW      = d2wpmd_pkg::WORD_W;
   localparam int NW      = d2wpmd_pkg::CNT_W;
   localparam int SW      = d2wpmd_pkg::SCORE_W;

   logic [WW-1:0] src_words_mem [MAX_WORDS];
   logic [WW-1:0] tgt_words_mem [MAX_WORDS];
   logic [NW-1:0] src_cnt_mem [WORD_SPACE];
   logic [NW-1:0] tgt_cnt_mem [WORD_SPACE];

   logic [PX_W-1:0] load_px, rd_px;
   logic            load_ok, rd_ok;
   logic [AW-1:0]   load_addr, rd_addr;

   logic [WW-1:0] src_word_ff, tgt_word_ff;
   logic          rd_src_ff, rd_ok_ff;
   logic [WW-1:0] word_sel;
   logic [WW-1:0] word_m_ff;
   logic [WW-1:0] q_ff;
   logic [WW+RECIP_W-1:0] prod;
   logic [PX_W-1:0] rem_w;
   logic [CW-1:0]   code;
   logic [CW-1:0]   code_ff;
   logic [NW-1:0]   src_cnt_ff, tgt_cnt_ff;
   logic [NW-1:0]   cnt_a, cnt_b, cnt_a_new;
   logic signed [12:0] diff;
   logic signed [23:0] delta, run_sum;
   logic [SW-1:0] running_ff, running_in;
   logic [SW-1:0] best_ff, best_in;
   logic [SW-1:0] score_ff, score_in;
   logic [SW-1:0] thr10;

   assign load_px   = {7'b0, cmd.load_pos};
   assign rd_px     = {7'b0, cmd.op_pos};
   assign load_ok   = load_px < PX_W'(MAX_WORDS);
   assign rd_ok     = rd_px < PX_W'(MAX_WORDS);
   assign load_addr = load_px[AW-1:0];
   assign rd_addr   = rd_px[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_en && load_ok && cmd.load_src) begin
         src_words_mem[load_addr] <= cmd.load_word;
      end
      if (cmd.word_rd) begin
         src_word_ff <= src_words_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_en && load_ok && !cmd.load_src) begin
         tgt_words_mem[load_addr] <= cmd.load_word;
      end
      if (cmd.word_rd) begin
         tgt_word_ff <= tgt_words_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.word_rd) begin
         rd_src_ff <= cmd.op_src;
         rd_ok_ff  <= rd_ok;
      end
   end

   assign word_sel = !rd_ok_ff ? '0 : (rd_src_ff ? src_word_ff : tgt_word_ff);
   assign prod     = word_sel * RECIP_W'(RECIP);

   always_ff @(posedge clock) begin
      if (cmd.mod_en) begin
         word_m_ff <= word_sel;
         q_ff      <= WW'(prod >> 24);
      end
   end

   assign rem_w = {5'b0, word_m_ff} - PX_W'(q_ff * WORD_SPACE);
   assign code  = rem_w[CW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         src_cnt_mem[cmd.clear_addr[CW-1:0]] <= '0;
      end else if (cmd.upd_en && cmd.op_src) begin
         src_cnt_mem[code_ff] <= cnt_a_new;
      end
      if (cmd.cnt_rd) begin
         src_cnt_ff <= src_cnt_mem[code];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         tgt_cnt_mem[cmd.clear_addr[CW-1:0]] <= '0;
      end else if (cmd.upd_en && !cmd.op_src) begin
         tgt_cnt_mem[code_ff] <= cnt_a_new;
      end
      if (cmd.cnt_rd) begin
         tgt_cnt_ff <= tgt_cnt_mem[code];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_rd) begin
         code_ff <= code;
      end
   end

   assign cnt_a     = cmd.op_src ? src_cnt_ff : tgt_cnt_ff;
   assign cnt_b     = cmd.op_src ? tgt_cnt_ff : src_cnt_ff;
   assign cnt_a_new = cmd.op_put ? cnt_a + NW'(1) : cnt_a - NW'(1);
   assign diff      = $signed({2'b0, cnt_a}) - $signed({2'b0, cnt_b});
   assign delta     = cmd.op_put ? (24'(diff) <<< 1) + 24'sd1 : 24'sd1 - (24'(diff) <<< 1);
   assign run_sum   = $signed({2'b0, running_ff}) + delta;
   assign thr10     = ({6'b0, cmd.threshold} << 3) + ({6'b0, cmd.threshold} << 1);

   always_comb begin
      running_in = running_ff;
      if (cmd.clear_en) begin
         running_in = '0;
      end else if (cmd.upd_en) begin
         running_in = run_sum[SW-1:0];
      end
      best_in = best_ff;
      if (cmd.note_en) begin
         if (cmd.note_init || running_ff < best_ff) begin
            best_in = running_ff;
         end
      end
      score_in = score_ff;
      if (cmd.rsp_load) begin
         score_in = cmd.rsp_short ? thr10 : best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         best_ff    <= '0;
      end else begin
         running_ff <= running_in;
         best_ff    <= best_in;
      end
      score_ff <= score_in;
   end

   assign stat.best_le_thr = best_ff <= {6'b0, cmd.threshold};
   assign score            = score_ff;

endmodule
`default_nettype wire

>>> rtl/d2wpmd_ctrl.sv
// Controller: configuration registers, search sequencer and response handshake.
`timescale 1ns / 1ps
`default_nettype none
module d2wpmd_ctrl #(
   parameter int WORD_SPACE = 4096
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [63:0]                      req_tdata,
   input  wire  [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [1:0]                       rsp_status,
   input  wire                              csr_we,
   input  wire  [d2wpmd_pkg::CSR_W-1:0]     csr_index,
   input  wire  [d2wpmd_pkg::THR_W-1:0]     csr_wdata,
   input  wire  d2wpmd_pkg::stat_type       stat,
   output d2wpmd_pkg::cmd_type              cmd
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CLEAR  = 9'b000000010,
      ST_OP_RD  = 9'b000000100,
      ST_OP_MOD = 9'b000001000,
      ST_OP_CNT = 9'b000010000,
      ST_OP_UPD = 9'b000100000,
      ST_NOTE   = 9'b001000000,
      ST_STEP   = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      KIND_INIT  = 2'd0,
      KIND_TFWD  = 2'd1,
      KIND_TBWD  = 2'd2,
      KIND_SSTEP = 2'd3
   } kind_type;

   localparam int CLRC_W  = $clog2(WORD_SPACE) + 1;
   localparam int CLR_W_T = d2wpmd_pkg::CLR_W;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic half_ff, half_in, dir_ff, dir_in, short_ff, short_in, note_init_ff, note_init_in;
   logic [1:0] stat_ff, stat_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [10:0] wlen_ff;
   logic [2:0]  klen_ff;
   logic [15:0] thr_ff;
   logic [10:0] nw_ff, nw_in, i_ff, i_in;
   logic [9:0]  sf_ff, sf_in, tf_ff, tf_in, slast_ff, slast_in, tlast_ff, tlast_in;
   logic [9:0]  s_ff, s_in, t_ff, t_in;
   logic [CLRC_W-1:0] clr_ff, clr_in;

   logic [9:0] f_pos, f_sf, f_sl, f_tf, f_tl;
   logic [11:0] f_word;
   logic accept;
   logic signed [12:0] nw_s, slen, tlen, slast_s, tlast_s;
   logic range_short;
   logic [10:0] pos_sum;
   logic op_src, op_put;

   assign f_pos     = req_tdata[9:0];
   assign f_word    = req_tdata[21:10];
   assign f_sf      = req_tdata[31:22];
   assign f_sl      = req_tdata[41:32];
   assign f_tf      = req_tdata[51:42];
   assign f_tl      = req_tdata[61:52];
   assign accept    = req_tvalid && req_tready;
   assign req_tready = state_ff == ST_IDLE;

   assign nw_s    = $signed({2'b0, wlen_ff}) - $signed({10'b0, klen_ff}) + 13'sd1;
   assign slen    = $signed({3'b0, f_sl}) - $signed({3'b0, f_sf}) + 13'sd1;
   assign tlen    = $signed({3'b0, f_tl}) - $signed({3'b0, f_tf}) + 13'sd1;
   assign slast_s = $signed({3'b0, f_sl}) - nw_s + 13'sd1;
   assign tlast_s = $signed({3'b0, f_tl}) - nw_s + 13'sd1;
   assign range_short = (nw_s < 13'sd1) || (slen < nw_s) || (tlen < nw_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= 11'd100;
         klen_ff <= 3'd6;
         thr_ff  <= 16'd40;
      end else if (csr_we) begin
         case (csr_index)
            d2wpmd_pkg::CSR_WINDOW_LENGTH: wlen_ff <= csr_wdata[10:0];
            d2wpmd_pkg::CSR_WORD_LENGTH:   klen_ff <= csr_wdata[2:0];
            d2wpmd_pkg::CSR_THRESHOLD:     thr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (kind_ff)
         KIND_INIT:  pos_sum = half_ff ? {1'b0, tf_ff} + 11'(i_ff) : {1'b0, sf_ff} + 11'(i_ff);
         KIND_TFWD:  pos_sum = half_ff ? {1'b0, t_ff} + nw_ff : {1'b0, t_ff};
         KIND_TBWD:  pos_sum = half_ff ? {1'b0, t_ff} - 11'd1 : {1'b0, t_ff} + nw_ff - 11'd1;
         KIND_SSTEP: pos_sum = half_ff ? {1'b0, s_ff} + nw_ff : {1'b0, s_ff};
         default:    pos_sum = '0;
      endcase
      op_src = (kind_ff == KIND_INIT) ? !half_ff : (kind_ff == KIND_SSTEP);
      op_put = half_ff || (kind_ff == KIND_INIT);
   end

   always_comb begin
      state_in = state_ff;   kind_in = kind_ff;   half_in = half_ff;
      dir_in = dir_ff;       short_in = short_ff; stat_in = stat_ff;
      note_init_in = note_init_ff;
      nw_in = nw_ff; i_in = i_ff; sf_in = sf_ff; tf_in = tf_ff;
      slast_in = slast_ff; tlast_in = tlast_ff; s_in = s_ff; t_in = t_ff;
      clr_in = clr_ff;
      rsp_load = 1'b0;

      cmd = '0;
      cmd.threshold = thr_ff;
      cmd.load_src  = req_tuser == d2wpmd_pkg::ACT_LOAD_SRC;
      cmd.load_pos  = f_pos;
      cmd.load_word = f_word;
      cmd.clear_addr = CLR_W_T'(clr_ff);
      cmd.op_src    = op_src;
      cmd.op_pos    = pos_sum[9:0];
      cmd.op_put    = op_put;
      cmd.note_init = note_init_ff;
      cmd.rsp_short = short_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_en = (req_tuser == d2wpmd_pkg::ACT_LOAD_SRC) ||
                             (req_tuser == d2wpmd_pkg::ACT_LOAD_TGT);
               if (req_tuser == d2wpmd_pkg::ACT_COMPUTE) begin
                  sf_in = f_sf; tf_in = f_tf; s_in = f_sf; t_in = f_tf;
                  nw_in = nw_s[10:0];
                  slast_in = slast_s[9:0];
                  tlast_in = tlast_s[9:0];
                  clr_in = '0;
                  if (range_short) begin
                     short_in = 1'b1;
                     stat_in  = d2wpmd_pkg::STAT_SHORT;
                     state_in = ST_DONE;
                  end else begin
                     short_in = 1'b0;
                     state_in = ST_CLEAR;
                  end
               end
            end
         end
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            clr_in = clr_ff + CLRC_W'(1);
            if (clr_ff == CLRC_W'(WORD_SPACE - 1)) begin
               kind_in = KIND_INIT; half_in = 1'b0; i_in = '0; dir_in = 1'b0;
               note_init_in = 1'b1;
               state_in = ST_OP_RD;
            end
         end
         ST_OP_RD: begin
            cmd.word_rd = 1'b1;
            state_in = ST_OP_MOD;
         end
         ST_OP_MOD: begin
            cmd.mod_en = 1'b1;
            state_in = ST_OP_CNT;
         end
         ST_OP_CNT: begin
            cmd.cnt_rd = 1'b1;
            state_in = ST_OP_UPD;
         end
         ST_OP_UPD: begin
            cmd.upd_en = 1'b1;
            state_in = ST_OP_RD;
            if (!half_ff) begin
               half_in = 1'b1;
            end else begin
               half_in = 1'b0;
               case (kind_ff)
                  KIND_INIT: begin
                     i_in = i_ff + 11'd1;
                     if (i_ff == nw_ff - 11'd1) begin
                        state_in = ST_NOTE;
                     end
                  end
                  KIND_TFWD: begin
                     t_in = t_ff + 10'd1;
                     state_in = ST_NOTE;
                  end
                  KIND_TBWD: begin
                     t_in = t_ff - 10'd1;
                     state_in = ST_NOTE;
                  end
                  default: begin
                     s_in = s_ff + 10'd1;
                     dir_in = !dir_ff;
                     state_in = ST_NOTE;
                  end
               endcase
            end
         end
         ST_NOTE: begin
            cmd.note_en = 1'b1;
            note_init_in = 1'b0;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            state_in = ST_OP_RD;
            if (stat.best_le_thr) begin
               stat_in = d2wpmd_pkg::STAT_THR;
               state_in = ST_DONE;
            end else if (!dir_ff && t_ff < tlast_ff) begin
               kind_in = KIND_TFWD;
            end else if (dir_ff && t_ff > tf_ff) begin
               kind_in = KIND_TBWD;
            end else if (s_ff >= slast_ff) begin
               stat_in = d2wpmd_pkg::STAT_FULL;
               state_in = ST_DONE;
            end else begin
               kind_in = KIND_SSTEP;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in  = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      rsp_status_in = rsp_load ? stat_ff : rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= KIND_INIT;
         half_ff      <= 1'b0;
         dir_ff       <= 1'b0;
         note_init_ff <= 1'b0;
         s_ff         <= '0;
         t_ff         <= '0;
         clr_ff       <= '0;
         i_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
         half_ff      <= half_in;
         dir_ff       <= dir_in;
         note_init_ff <= note_init_in;
         s_ff         <= s_in;
         t_ff         <= t_in;
         clr_ff       <= clr_in;
         i_ff         <= i_in;
      end
      short_ff      <= short_in;
      stat_ff       <= stat_in;
      nw_ff         <= nw_in;
      sf_ff         <= sf_in;
      tf_ff         <= tf_in;
      slast_ff      <= slast_in;
      tlast_ff      <= tlast_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   a_t_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && !short_ff) |-> (t_ff >= tf_ff && t_ff <= tlast_ff))
      else $error("target cursor left its range");

   a_s_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && !short_ff) |-> (s_ff >= sf_ff && s_ff <= slast_ff))
      else $error("source cursor left its range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !cmd.load_en)
      else $error("load written while a search runs");

endmodule
`default_nettype wire

>>> rtl/d2_window_pair_min_distance_top.sv
// Top level of the window-pair minimum distance search block.
//
//  channel | dir | handshake                 | payload
//  req     | in  | req_tvalid / req_tready   | tuser action, tdata range and load fields
//  rsp     | out | rsp_tvalid / rsp_tready   | tdata score, tuser status
//  csr     | in  | csr_we                    | csr_index, csr_wdata
//
// For a compute transaction, the count tables are first cleared one entry a cycle,
// and every word update then runs a read, reduce, count read and write sequence
// through single-port count memories.
// Reset is synchronous; after it both word stores are undefined until loaded.
// A waiting response does not block loads; a compute waits at its end for the slot.
`timescale 1ns / 1ps
`default_nettype none
module d2_window_pair_min_distance_top #(
   parameter int WORD_SPACE = 4096,
   parameter int MAX_WORDS  = 1024
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // position, word, src_first, src_last, tgt_first, tgt_last
   input  wire  [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // score
   output logic [1:0]  rsp_tuser,   // status
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata
);

   d2wpmd_pkg::cmd_type  cmd;
   d2wpmd_pkg::stat_type stat;
   logic [d2wpmd_pkg::SCORE_W-1:0] score;

   d2wpmd_ctrl #(
      .WORD_SPACE(WORD_SPACE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .stat       (stat),
      .cmd        (cmd)
   );

   d2wpmd_datapath #(
      .WORD_SPACE(WORD_SPACE),
      .MAX_WORDS (MAX_WORDS)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat),
      .score (score)
   );

   assign rsp_tdata = {2'b00, score};

endmodule
`default_nettype wire
